[sv/tgadec_pkg.sv]
package tgadec_pkg;

    // parser phase codes
    localparam logic [2:0] PH_IDLE   = 3'd0;
    localparam logic [2:0] PH_HEADER = 3'd1;
    localparam logic [2:0] PH_PACKET = 3'd2;
    localparam logic [2:0] PH_PIXEL  = 3'd3;
    localparam logic [2:0] PH_DONE   = 3'd4;

    // result kinds
    localparam logic [1:0] KIND_PIXEL  = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_ERROR  = 2'd2;

    // error codes
    localparam logic [1:0] ERR_SIGNATURE  = 2'd0;
    localparam logic [1:0] ERR_SIZE_DEPTH = 2'd1;
    localparam logic [1:0] ERR_OVERFLOW   = 2'd2;

    // lead-in image type byte and header layout
    localparam logic [4:0] LEAD_LEN       = 5'd12;
    localparam logic [4:0] TYPE_INDEX     = 5'd2;
    localparam logic [7:0] TYPE_RAW       = 8'd2;
    localparam logic [7:0] TYPE_RLE       = 8'd10;
    localparam logic [4:0] IDX_WIDTH_LO   = 5'd12;
    localparam logic [4:0] IDX_WIDTH_HI   = 5'd13;
    localparam logic [4:0] IDX_HEIGHT_LO  = 5'd14;
    localparam logic [4:0] IDX_HEIGHT_HI  = 5'd15;
    localparam logic [4:0] IDX_DEPTH      = 5'd16;
    localparam logic [4:0] IDX_DESCRIPTOR = 5'd17;
    localparam logic [7:0] DEPTH_24       = 8'd24;
    localparam logic [7:0] DEPTH_32       = 8'd32;

    // result word width: 75 field bits padded to whole bytes
    localparam int OUT_DATA_W = 80;

endpackage

[sv/tga_image_decoder_core.sv]
// channel | dir | tdata (lsb up)                              | tuser         | tlast
// s_axis  | in  | file_byte[7:0]                              | start_of_file | -
// m_axis  | out | red, green, blue, alpha, run_length,        | kind[1:0]     | last
//         |     | image_width, image_height, alpha_present,   |               |
//         |     | error_code, zero pad to 80 bits             |               |
//
// one file byte per clock while the output is not stalled; a result appears in the cycle after the byte that causes it
// the only multiplication is the 16x16 width*height product, done on the descriptor byte
// one output register; input ready is high while it is empty or being drained
// rst_n clears the parser to idle; bytes are ignored until a word with start_of_file
// a stalled output holds its word and stalls the input
module tga_image_decoder_core
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [7:0]                         s_axis_tdata,  // file_byte
    input  logic                               s_axis_tuser,  // start_of_file
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // red[7:0], green[15:8], blue[23:16], alpha[31:24], run_length[39:32],
    // image_width[55:40], image_height[71:56], alpha_present[72],
    // error_code[74:73], zero pad[79:75]
    output logic [tgadec_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
    output logic [1:0]                         m_axis_tuser,  // kind
    output logic                               m_axis_tlast   // last
);

    import tgadec_pkg::*;

    // parser state
    logic [2:0]  phase_reg, phase_next;
    logic [4:0]  byte_idx_reg, byte_idx_next;
    logic        rle_reg, rle_next;
    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [7:0]  depth_reg, depth_next;
    logic        four_bpp_reg, four_bpp_next;
    logic [31:0] pixels_left_reg, pixels_left_next;
    logic [7:0]  packet_left_reg, packet_left_next;
    logic        packet_rep_reg, packet_rep_next;
    logic [7:0]  color_reg [3];
    logic        color_we;
    logic [1:0]  color_sel;

    // result register
    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg, out_data_next;
    logic [1:0]            out_kind_reg, out_kind_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_gen;

    logic        in_fire;
    logic [2:0]  phase_cur;
    logic [4:0]  byte_idx_cur;
    logic [4:0]  byte_idx_inc;
    logic [4:0]  need;
    logic [7:0]  b;
    logic        lead_ok;
    logic [7:0]  run_n;
    logic [31:0] area;
    logic [7:0]  px_red, px_green, px_blue, px_alpha, px_run;
    logic [1:0]  err_code;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign b             = s_axis_tdata;

    // start of file restarts the parser on this same word
    assign phase_cur    = s_axis_tuser ? PH_HEADER : phase_reg;
    assign byte_idx_cur = s_axis_tuser ? 5'd0 : byte_idx_reg;
    assign byte_idx_inc = byte_idx_cur + 5'd1;
    assign need         = four_bpp_reg ? 5'd4 : 5'd3;
    assign area         = 32'(width_reg) * 32'(height_reg);
    assign lead_ok      = (byte_idx_cur == TYPE_INDEX) ? (b == TYPE_RAW || b == TYPE_RLE)
                                                       : (b == 8'd0);

    // next state and result
    always_comb
    begin
        phase_next       = phase_reg;
        byte_idx_next    = byte_idx_reg;
        rle_next         = rle_reg;
        width_next       = width_reg;
        height_next      = height_reg;
        depth_next       = depth_reg;
        four_bpp_next    = four_bpp_reg;
        pixels_left_next = pixels_left_reg;
        packet_left_next = packet_left_reg;
        packet_rep_next  = packet_rep_reg;
        color_we         = 1'b0;
        color_sel        = byte_idx_cur[1:0];
        out_gen          = 1'b0;
        out_kind_next    = KIND_PIXEL;
        out_last_next    = 1'b0;
        px_red           = 8'd0;
        px_green         = 8'd0;
        px_blue          = 8'd0;
        px_alpha         = 8'd0;
        px_run           = 8'd0;
        err_code         = ERR_SIGNATURE;
        run_n            = 8'd1;
        out_data_next    = '0;

        if (s_axis_tuser)
        begin
            phase_next       = PH_HEADER;
            byte_idx_next    = 5'd0;
            rle_next         = 1'b0;
            width_next       = 16'd0;
            height_next      = 16'd0;
            depth_next       = 8'd0;
            four_bpp_next    = 1'b0;
            pixels_left_next = 32'd0;
            packet_left_next = 8'd0;
            packet_rep_next  = 1'b0;
        end

        case (phase_cur)
            PH_HEADER:
            begin
                if (byte_idx_cur < LEAD_LEN)
                begin
                    if (!lead_ok)
                    begin
                        out_gen       = 1'b1;
                        out_kind_next = KIND_ERROR;
                        err_code      = ERR_SIGNATURE;
                        phase_next    = PH_DONE;
                    end
                    else
                    begin
                        if (byte_idx_cur == TYPE_INDEX)
                            rle_next = (b == TYPE_RLE);
                        byte_idx_next = byte_idx_inc;
                    end
                end
                else if (byte_idx_cur < IDX_DESCRIPTOR)
                begin
                    case (byte_idx_cur)
                        IDX_WIDTH_LO:  width_next  = {8'd0, b};
                        IDX_WIDTH_HI:  width_next  = {b, width_reg[7:0]};
                        IDX_HEIGHT_LO: height_next = {8'd0, b};
                        IDX_HEIGHT_HI: height_next = {b, height_reg[7:0]};
                        IDX_DEPTH:     depth_next  = b;
                        default:       ;
                    endcase
                    byte_idx_next = byte_idx_inc;
                end
                else if (width_reg == 16'd0 || height_reg == 16'd0 ||
                         (depth_reg != DEPTH_24 && depth_reg != DEPTH_32))
                begin
                    out_gen       = 1'b1;
                    out_kind_next = KIND_ERROR;
                    err_code      = ERR_SIZE_DEPTH;
                    phase_next    = PH_DONE;
                end
                else
                begin
                    four_bpp_next    = (depth_reg == DEPTH_32);
                    pixels_left_next = area;
                    byte_idx_next    = 5'd0;
                    packet_left_next = 8'd0;
                    packet_rep_next  = 1'b0;
                    phase_next       = rle_reg ? PH_PACKET : PH_PIXEL;
                    out_gen          = 1'b1;
                    out_kind_next    = KIND_HEADER;
                end
            end

            PH_PACKET:
            begin
                // count is low seven bits plus one for both packet types
                packet_rep_next  = b[7];
                packet_left_next = {1'b0, b[6:0]} + 8'd1;
                byte_idx_next    = 5'd0;
                phase_next       = PH_PIXEL;
            end

            PH_PIXEL:
            begin
                if (byte_idx_inc != need)
                begin
                    color_we      = (byte_idx_cur < 5'd3);
                    byte_idx_next = byte_idx_inc;
                end
                else
                begin
                    byte_idx_next = 5'd0;
                    if (rle_reg && packet_rep_reg)
                    begin
                        run_n            = packet_left_reg;
                        packet_left_next = 8'd0;
                    end
                    else if (rle_reg && packet_left_reg != 8'd0)
                    begin
                        packet_left_next = packet_left_reg - 8'd1;
                    end
                    out_gen = 1'b1;
                    if (32'(run_n) > pixels_left_reg)
                    begin
                        out_kind_next = KIND_ERROR;
                        err_code      = ERR_OVERFLOW;
                        phase_next    = PH_DONE;
                    end
                    else
                    begin
                        pixels_left_next = pixels_left_reg - 32'(run_n);
                        out_last_next    = (pixels_left_next == 32'd0) &&
                                           (!rle_reg || packet_left_next == 8'd0);
                        out_kind_next    = KIND_PIXEL;
                        px_red           = four_bpp_reg ? color_reg[2] : b;
                        px_green         = color_reg[1];
                        px_blue          = color_reg[0];
                        px_alpha         = four_bpp_reg ? b : 8'd0;
                        px_run           = run_n;
                        if (out_last_next)
                            phase_next = PH_DONE;
                        else if (rle_reg && packet_left_next == 8'd0)
                            phase_next = PH_PACKET;
                    end
                end
            end

            default:
            begin
            end
        endcase

        // pack the result word
        case (out_kind_next)
            KIND_PIXEL:
                out_data_next = {5'd0, 2'd0, four_bpp_reg, 16'd0, 16'd0,
                                 px_run, px_alpha, px_blue, px_green, px_red};
            KIND_HEADER:
                out_data_next = {5'd0, 2'd0, four_bpp_next, height_reg, width_reg,
                                 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
            default:
                out_data_next = {5'd0, err_code, 1'b0, 16'd0, 16'd0,
                                 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
        endcase
    end

    // parser registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            byte_idx_reg    <= 5'd0;
            rle_reg         <= 1'b0;
            width_reg       <= 16'd0;
            height_reg      <= 16'd0;
            depth_reg       <= 8'd0;
            four_bpp_reg    <= 1'b0;
            pixels_left_reg <= 32'd0;
            packet_left_reg <= 8'd0;
            packet_rep_reg  <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg       <= phase_next;
            byte_idx_reg    <= byte_idx_next;
            rle_reg         <= rle_next;
            width_reg       <= width_next;
            height_reg      <= height_next;
            depth_reg       <= depth_next;
            four_bpp_reg    <= four_bpp_next;
            pixels_left_reg <= pixels_left_next;
            packet_left_reg <= packet_left_next;
            packet_rep_reg  <= packet_rep_next;
        end
    end

    // pixel byte store
    always_ff @(posedge clk)
    begin
        if (in_fire && color_we)
            color_reg[color_sel] <= b;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (in_fire)
            out_valid_reg <= out_gen;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && out_gen)
        begin
            out_data_reg <= out_data_next;
            out_kind_reg <= out_kind_next;
            out_last_reg <= out_last_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

    // a pending word that is not taken blocks the input
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted over a stalled result");

    // errors and last pixels end the file
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && out_gen && (out_kind_next == KIND_ERROR || out_last_next))
        |=> phase_reg == PH_DONE)
        else $error("parser did not stop after error or last pixel");

    // repeat runs only come from run-length images
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_fire && out_gen && out_kind_next == KIND_PIXEL && px_run != 8'd1) |-> rle_reg)
        else $error("run longer than one in a raw image");

    // pixel byte counter stays within one pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PIXEL) |-> (byte_idx_reg < 5'd4))
        else $error("pixel byte index out of range");

endmodule

[dv/tga_decode_checker.sv]
module tga_decode_checker
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    input  logic                               s_tready,
    input  logic [7:0]                         s_tdata,   // file_byte
    input  logic                               s_tuser,   // start_of_file
    input  logic                               m_tvalid,
    input  logic                               m_tready,
    input  logic [tgadec_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic [1:0]                         m_tuser,   // kind
    input  logic                               m_tlast,
    output int                                 fail_count,
    output int                                 outstanding
);

    import tgadec_pkg::*;

    // one decoded result word, fields in reporting order
    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [7:0]  run_len;
        logic [15:0] img_w;
        logic [15:0] img_h;
        logic        alpha_on;
        logic [1:0]  err;
        logic        last;
        logic [4:0]  pad;
    } pixel_word_t;

    // decoder state mirrored from the block's behavior
    logic [2:0]  dec_phase;
    logic [4:0]  byte_pos;
    logic        rle_image;
    logic [15:0] width_q;
    logic [15:0] height_q;
    logic        wide_pixel;
    logic [31:0] pixels_owed;
    logic [7:0]  packet_cnt;
    logic        packet_rep;
    logic [7:0]  color_q [4];

    pixel_word_t words_due [$];
    int          fails = 0;

    function automatic void clear_decoder();
        dec_phase   = PH_IDLE;
        byte_pos    = '0;
        rle_image   = 1'b0;
        width_q     = '0;
        height_q    = '0;
        wide_pixel  = 1'b0;
        pixels_owed = '0;
        packet_cnt  = '0;
        packet_rep  = 1'b0;
        for (int i = 0; i < 4; i++)
            color_q[i] = '0;
    endfunction

    function automatic logic flag_error(input logic [1:0] code, output pixel_word_t r);
        r         = '0;
        r.kind    = KIND_ERROR;
        r.err     = code;
        dec_phase = PH_DONE;
        return 1'b1;
    endfunction

    // advance the decoder by one file byte; returns 1 when a word is produced
    function automatic logic decode_byte(input logic [7:0] b, input logic sof,
                                         output pixel_word_t r);
        logic [31:0] n;
        logic [4:0]  need;
        logic        done;
        r = '0;
        if (sof)
        begin
            clear_decoder();
            dec_phase = PH_HEADER;
        end
        case (dec_phase)
            PH_HEADER:
            begin
                // fixed lead-in: all zero except the image type byte
                if (byte_pos < LEAD_LEN)
                begin
                    if (byte_pos == TYPE_INDEX ? (b != TYPE_RAW && b != TYPE_RLE)
                                               : (b != 8'd0))
                        return flag_error(ERR_SIGNATURE, r);
                    if (byte_pos == TYPE_INDEX)
                        rle_image = (b == TYPE_RLE);
                    byte_pos++;
                    return 1'b0;
                end
                case (byte_pos)
                    IDX_WIDTH_LO:  width_q  = {8'h00, b};
                    IDX_WIDTH_HI:  width_q  = {b, width_q[7:0]};
                    IDX_HEIGHT_LO: height_q = {8'h00, b};
                    IDX_HEIGHT_HI: height_q = {b, height_q[7:0]};
                    IDX_DEPTH:     color_q[0] = b;
                    default: ;
                endcase
                if (byte_pos < IDX_DESCRIPTOR)
                begin
                    byte_pos++;
                    return 1'b0;
                end
                if (width_q == 0 || height_q == 0 ||
                    (color_q[0] != DEPTH_24 && color_q[0] != DEPTH_32))
                    return flag_error(ERR_SIZE_DEPTH, r);
                wide_pixel = (color_q[0] == DEPTH_32);
                for (int i = 0; i < 4; i++)
                    color_q[i] = '0;
                pixels_owed = {16'h0, width_q} * {16'h0, height_q};
                byte_pos    = '0;
                packet_cnt  = '0;
                packet_rep  = 1'b0;
                dec_phase   = rle_image ? PH_PACKET : PH_PIXEL;
                r.kind      = KIND_HEADER;
                r.img_w     = width_q;
                r.img_h     = height_q;
                r.alpha_on  = wide_pixel;
                return 1'b1;
            end
            PH_PACKET:
            begin
                // top bit set means one pixel repeated, else a run of raw pixels
                if (b[7])
                begin
                    packet_rep = 1'b1;
                    packet_cnt = b - 8'd127;
                end
                else
                begin
                    packet_rep = 1'b0;
                    packet_cnt = b + 8'd1;
                end
                byte_pos  = '0;
                dec_phase = PH_PIXEL;
                return 1'b0;
            end
            PH_PIXEL:
            begin
                color_q[byte_pos[1:0]] = b;
                byte_pos = byte_pos + 5'd1;
                need = wide_pixel ? 5'd4 : 5'd3;
                if (byte_pos < need)
                    return 1'b0;
                byte_pos = '0;
                n = 32'd1;
                if (rle_image)
                begin
                    if (packet_rep)
                    begin
                        n = {24'h0, packet_cnt};
                        packet_cnt = '0;
                    end
                    else if (packet_cnt > 0)
                        packet_cnt--;
                end
                if (n > pixels_owed)
                    return flag_error(ERR_OVERFLOW, r);
                pixels_owed -= n;
                done = (pixels_owed == 0) && (!rle_image || packet_cnt == 0);
                r.kind     = KIND_PIXEL;
                r.red      = color_q[2];
                r.green    = color_q[1];
                r.blue     = color_q[0];
                r.alpha    = wide_pixel ? color_q[3] : 8'h00;
                r.run_len  = n[7:0];
                r.alpha_on = wide_pixel;
                r.last     = done;
                if (done)
                    dec_phase = PH_DONE;
                else if (rle_image && packet_cnt == 0)
                    dec_phase = PH_PACKET;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    function automatic string show(input pixel_word_t r);
        return {$sformatf("kind=%0d rgba=%02h_%02h_%02h_%02h run=%0d ",
                          r.kind, r.red, r.green, r.blue, r.alpha, r.run_len),
                $sformatf("size=%0dx%0d a=%0d err=%0d last=%0d pad=%0h",
                          r.img_w, r.img_h, r.alpha_on, r.err, r.last, r.pad)};
    endfunction

    // compare delivered words first, then predict from the byte taken at this edge
    always @(posedge clk)
    begin : watch
        pixel_word_t got;
        pixel_word_t want;
        if (!rst_n)
        begin
            clear_decoder();
            words_due.delete();
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                got.kind     = m_tuser;
                got.red      = m_tdata[7:0];
                got.green    = m_tdata[15:8];
                got.blue     = m_tdata[23:16];
                got.alpha    = m_tdata[31:24];
                got.run_len  = m_tdata[39:32];
                got.img_w    = m_tdata[55:40];
                got.img_h    = m_tdata[71:56];
                got.alpha_on = m_tdata[72];
                got.err      = m_tdata[74:73];
                got.pad      = m_tdata[79:75];
                got.last     = m_tlast;
                if (words_due.size() == 0)
                begin
                    if (fails < 10)
                        $display("unexpected result word: %s", show(got));
                    fails++;
                end
                else
                begin
                    want = words_due.pop_front();
                    if (got != want)
                    begin
                        if (fails < 10)
                        begin
                            $display("result mismatch, expected %s", show(want));
                            $display("                 actual   %s", show(got));
                        end
                        fails++;
                    end
                end
            end
            if (s_tvalid && s_tready)
            begin
                if (decode_byte(s_tdata, s_tuser, want))
                    words_due.push_back(want);
            end
        end
        outstanding <= words_due.size();
        fail_count  <= fails;
    end

endmodule

[dv/tb.sv]
module tb;
    import tgadec_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [7:0]             s_tdata = '0;
    logic                   s_tuser = 1'b0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [1:0]             m_tuser;
    logic                   m_tlast;

    int fail_count;
    int outstanding;
    int cycles = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;

    // pending file bytes, bit 8 is the start-of-file flag
    logic [8:0] stream [$];

    tga_image_decoder_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tuser  (m_tuser),
        .m_axis_tlast  (m_tlast)
    );

    tga_decode_checker chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always #5 clk = ~clk;

    // receiver back-pressure
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    // watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("[tga_image_decoder_core] ERROR");
            $finish;
        end
    end

    function automatic logic [7:0] pick_color();
        if ($urandom_range(7) == 0)
            return $urandom_range(1) ? 8'hFF : 8'h00;
        return 8'($urandom_range(255));
    endfunction

    task automatic put_byte(input logic [7:0] b);
        stream.push_back({1'b0, b});
    endtask

    task automatic put_start(input logic [7:0] b);
        stream.push_back({1'b1, b});
    endtask

    task automatic put_header(input logic rle, input logic [15:0] w, input logic [15:0] h,
                              input logic [7:0] depth);
        put_start(8'h00);
        put_byte(8'h00);
        put_byte(rle ? TYPE_RLE : TYPE_RAW);
        repeat (9) put_byte(8'h00);
        put_byte(w[7:0]);
        put_byte(w[15:8]);
        put_byte(h[7:0]);
        put_byte(h[15:8]);
        put_byte(depth);
        put_byte(8'($urandom_range(255)));
    endtask

    task automatic put_pixels(input int n, input logic wide);
        repeat (n * (wide ? 4 : 3)) put_byte(pick_color());
    endtask

    // well-formed run-length body covering exactly px pixels
    task automatic put_rle_body(input int px, input logic wide);
        int cnt;
        int lim;
        while (px > 0)
        begin
            if ($urandom_range(1))
            begin
                lim = (px < 128) ? px : 128;
                cnt = $urandom_range(lim, 1);
                put_byte(8'(127 + cnt));
                put_pixels(1, wide);
            end
            else
            begin
                lim = ($urandom_range(29) == 0) ? 128 : 4;
                if (lim > px)
                    lim = px;
                cnt = $urandom_range(lim, 1);
                put_byte(8'(cnt - 1));
                put_pixels(cnt, wide);
            end
            px -= cnt;
        end
    endtask

    // one file, mostly well formed, the rest with a fault injected
    task automatic random_file();
        int          fault;
        int          base;
        int          px;
        longint      total;
        logic        rle;
        logic        wide;
        logic        big;
        logic [15:0] w;
        logic [15:0] h;
        logic [7:0]  depth;
        logic [8:0]  tmp;
        fault = $urandom_range(99);
        rle   = $urandom_range(1);
        wide  = $urandom_range(1);
        big   = ($urandom_range(99) < 6);
        depth = wide ? DEPTH_32 : DEPTH_24;
        if (big)
        begin
            rle = 1'b1;
            w   = 16'($urandom_range(65535, 1));
            h   = 16'($urandom_range(65535, 1));
        end
        else
        begin
            w = 16'($urandom_range(4, 1));
            h = 16'($urandom_range(4, 1));
        end
        // bad size or depth
        if (fault >= 85 && fault < 90)
        begin
            case ($urandom_range(2))
                0: w = '0;
                1: h = '0;
                default: depth = 8'($urandom_range(255));
            endcase
        end
        base = stream.size();
        put_header(rle, w, h, depth);
        // corrupted lead-in
        if (fault >= 80 && fault < 85)
        begin
            px = base + $urandom_range(11);
            tmp = stream[px];
            tmp[7:0] = 8'($urandom_range(255));
            stream[px] = tmp;
        end
        total = longint'(w) * longint'(h);
        px = big ? $urandom_range(40, 1) : int'(total);
        if (px > total)
            px = int'(total);
        if (rle)
            put_rle_body(px, wide);
        else
            put_pixels(px, wide);
        // more pixels than the image holds
        if (fault >= 90 && fault < 95)
        begin
            if (rle)
                put_byte($urandom_range(1) ? 8'(8'h80 + $urandom_range(127)) : 8'h00);
            put_pixels(1, wide);
        end
        // truncation or trailing garbage
        if (fault >= 95)
        begin
            if ($urandom_range(1))
            begin
                repeat ($urandom_range(6, 1))
                    if (stream.size() > base + 18)
                        void'(stream.pop_back());
            end
            else
                repeat ($urandom_range(6, 1)) put_byte(8'($urandom_range(255)));
        end
    endtask

    task automatic send_word(input logic [8:0] w);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= w[8];
        s_tdata  <= w[7:0];
        do @(posedge clk); while (!s_tready);
    endtask

    task automatic drain_stream();
        while (stream.size() != 0)
            send_word(stream.pop_front());
    endtask

    // sender waits until every predicted word has been delivered
    task automatic hold_off();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    initial
    begin : stimulus
        int sent;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // bytes ahead of any start are dropped
        put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(8'hA5);
        // raw 24-bit single pixel, then bytes past the image end
        put_header(1'b0, 16'd1, 16'd1, DEPTH_24);
        put_byte(8'h00); put_byte(8'h80); put_byte(8'hFF);
        put_byte(8'h12); put_byte(8'h34);
        // raw 32-bit two pixels, the first with extreme channel values
        put_header(1'b0, 16'd2, 16'd1, DEPTH_32);
        put_byte(8'hFF); put_byte(8'h00); put_byte(8'hFF); put_byte(8'h00);
        put_byte(8'h01); put_byte(8'h02); put_byte(8'h03); put_byte(8'h04);
        // run-length 24-bit: repeat packet then raw packet
        put_header(1'b1, 16'd2, 16'd2, DEPTH_24);
        put_byte(8'h81); put_byte(8'hAA); put_byte(8'hBB); put_byte(8'hCC);
        put_byte(8'h01); put_pixels(2, 1'b0);
        // longest repeat run fills the image
        put_header(1'b1, 16'd128, 16'd1, DEPTH_32);
        put_byte(8'hFF); put_pixels(1, 1'b1);
        // bad signature at byte zero, at the type byte, at the last lead-in byte
        put_start(8'h01); put_byte(8'h00); put_byte(TYPE_RAW);
        put_start(8'h00); put_byte(8'h00); put_byte(8'h03);
        put_start(8'h00); put_byte(8'h00); put_byte(TYPE_RLE);
        repeat (8) put_byte(8'h00);
        put_byte(8'h80);
        // zero width, zero height, unsupported depth
        put_header(1'b0, 16'd0, 16'd5, DEPTH_24);
        put_header(1'b1, 16'd5, 16'd0, DEPTH_32);
        put_header(1'b0, 16'd3, 16'd3, 8'd16);
        // raw image with one pixel too many
        put_header(1'b0, 16'd1, 16'd1, DEPTH_24);
        put_pixels(2, 1'b0);
        // repeat run longer than the image
        put_header(1'b1, 16'd1, 16'd1, DEPTH_24);
        put_byte(8'h81); put_pixels(1, 1'b0);
        // raw packet running past the image end
        put_header(1'b1, 16'd1, 16'd1, DEPTH_32);
        put_byte(8'h01); put_pixels(2, 1'b1);
        // restart in the middle of a header
        put_start(8'h00); put_byte(8'h00); put_byte(TYPE_RAW);
        repeat (5) put_byte(8'h00);
        // largest image, cut short by the next start
        put_header(1'b1, 16'hFFFF, 16'hFFFF, DEPTH_32);
        put_byte(8'hFF); put_pixels(1, 1'b1);
        put_byte(8'h00); put_pixels(1, 1'b1);
        put_byte(8'h80); put_pixels(1, 1'b1);
        drain_stream();
        hold_off();

        // random files under each idling pattern
        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:       begin send_idle_pct = 0;  stall_pct = 0;  end
                1:       begin send_idle_pct = 72; stall_pct = 0;  end
                2:       begin send_idle_pct = 0;  stall_pct = 72; end
                default: begin send_idle_pct = 18; stall_pct = 18; end
            endcase
            sent = 0;
            while (sent < 200)
            begin
                random_file();
                sent += stream.size();
                drain_stream();
            end
            hold_off();
        end

        send_idle_pct = 0;
        stall_pct     = 0;
        repeat (8) @(posedge clk);
        if (fail_count == 0 && outstanding == 0)
            $display("[tga_image_decoder_core] OK");
        else
            $display("[tga_image_decoder_core] ERROR");
        $finish;
    end

endmodule
